[hw/rtl/flb_pkg.sv]
// Shared types, constants and functions of the flowlet token load balancer.
package flb_pkg;

  localparam int NUM_PORTS_DEF = 4;
  localparam int MAX_LANES     = 4;
  localparam int TABLE_DEPTH   = 65536;
  localparam int TABLE_AW      = 16;
  localparam int QUOT_BITS     = 16;
  localparam int CRC_BYTES     = 13;
  localparam int MSG_BITS      = 8 * CRC_BYTES;

  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] NO_L4_PORT = 16'hFFFF;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  localparam logic [2:0]  PORT_COUNT_RST = 3'd4;
  localparam logic [15:0] WEIGHT_RST     = 16'd1;
  localparam logic [31:0] HOLD_TIME_RST  = 32'd0;
  localparam logic [31:0] AGE_LIMIT_RST  = 32'd120000;

  typedef enum logic [2:0] {
    CFG_PORT_COUNT = 3'd0,
    CFG_WEIGHT_0   = 3'd1,
    CFG_WEIGHT_1   = 3'd2,
    CFG_WEIGHT_2   = 3'd3,
    CFG_WEIGHT_3   = 3'd4,
    CFG_HOLD_TIME  = 3'd5,
    CFG_AGE_LIMIT  = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CALC,
    ST_CREDIT,
    ST_LOOK,
    ST_BEST,
    ST_WRITE,
    ST_SWEEP
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [63:0] last_time;
    logic [1:0]  port;
  } entry_t;

  typedef struct packed {
    logic                rd_en;
    logic [TABLE_AW-1:0] rd_addr;
    logic                wr_en;
    logic [TABLE_AW-1:0] wr_addr;
    entry_t              wr_data;
  } tbl_req_t;

  // Reflected CRC-16 over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  d;
    c = crc_in;
    d = b;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  // Signed compare of two 64-bit token counts.
  function automatic logic tok_less(input logic [63:0] a, input logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

[hw/rtl/flb_item_if.sv]
// Input word channel: packet header or tick.
interface flb_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] time_us;
  logic [15:0] pkt_length;
  logic [7:0]  protocol;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_l4_port;
  logic [15:0] dst_l4_port;

  modport source(output valid, kind, time_us, pkt_length, protocol, src_addr, dst_addr,
                 src_l4_port, dst_l4_port, input ready);
  modport sink(input valid, kind, time_us, pkt_length, protocol, src_addr, dst_addr,
               src_l4_port, dst_l4_port, output ready);
endinterface

[hw/rtl/flb_result_if.sv]
// Result word channel: chosen port and flow id.
interface flb_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_port;
  logic [15:0] flow_id;
  logic        new_choice;

  modport source(output valid, out_port, flow_id, new_choice, input ready);
  modport sink(input valid, out_port, flow_id, new_choice, output ready);
endinterface

[hw/rtl/flb_cfg_if.sv]
// Configuration write channel.
interface flb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/flowlet_token_load_balancer.sv]
// Flowlet token load balancer: control, token counters and configuration.
// Packet path: 16-step share divider, credit, table read, best-port scan and write-back.
// One word is handled at a time: a new word is accepted only in idle, after write-back,
// which waits while a result stalls on the output; a tick runs a table sweep. Reset:
// async active low; then a clearing pass over all 65536 entries zeroes the valid bits,
// accepting no word (config writes do).
module flowlet_token_load_balancer #(
  parameter int NUM_PORTS = flb_pkg::NUM_PORTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  flb_item_if.sink      item_in,
  flb_result_if.source  res_out,
  flb_cfg_if.sink       cfg_in
);

  localparam int LANES = (NUM_PORTS < flb_pkg::MAX_LANES) ? NUM_PORTS : flb_pkg::MAX_LANES;
  localparam int LIDX  = $clog2(LANES);
  localparam int AW    = flb_pkg::TABLE_AW;

  flb_pkg::state_e state_q, state_d;

  // Configuration
  logic [2:0]                    port_count_q;
  logic [flb_pkg::MAX_LANES-1:0][15:0] weight_q;
  logic [31:0]                   hold_q;
  logic [31:0]                   age_q;
  logic [2:0]                    n_act;
  logic [LANES-1:0][15:0]        lane_weight;

  // Datapath state
  logic [LANES-1:0][63:0]        tokens_q;
  logic [63:0]                   time_q;
  logic [15:0]                   len_q;
  logic [AW-1:0]                 addr_q;
  logic                          rd_live_q;
  logic                          chk_valid_q;
  logic [AW-1:0]                 chk_addr_q;
  logic                          keep_q;
  logic [1:0]                    kept_port_q;
  logic [LIDX-1:0]               best_idx_q;
  logic [LIDX-1:0]               best_i_q;

  logic                          res_valid_q;
  logic [1:0]                    res_port_q;
  logic [15:0]                   res_fid_q;
  logic                          res_new_q;

  logic                          in_acc;
  logic                          out_free;
  logic                          aged;
  logic                          keep_d;
  logic [1:0]                    port_sel;
  logic                          debit;
  logic [flb_pkg::MSG_BITS-1:0]  msg;
  logic [15:0]                   sp, dp;

  logic                          crc_busy, div_busy, div_nonzero;
  logic [15:0]                   fid;
  logic [LANES-1:0][15:0]        quot;
  flb_pkg::tbl_req_t             tbl_req;
  flb_pkg::entry_t               tbl_rd;

  assign in_acc   = item_in.valid && item_in.ready;
  assign out_free = !res_valid_q || res_out.ready;
  assign n_act    = (port_count_q > 3'(LANES)) ? 3'(LANES) : port_count_q;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_weight[i] = weight_q[i];
    end
  end

  // Build the hashed header, ports only for TCP and UDP
  always_comb begin
    if (item_in.protocol == flb_pkg::PROTO_TCP || item_in.protocol == flb_pkg::PROTO_UDP) begin
      sp = item_in.src_l4_port;
      dp = item_in.dst_l4_port;
    end else begin
      sp = flb_pkg::NO_L4_PORT;
      dp = flb_pkg::NO_L4_PORT;
    end
    msg = {item_in.protocol, item_in.src_addr, item_in.dst_addr, sp, dp};
  end

  flb_crc u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && !item_in.kind),
    .msg_i   (msg),
    .busy_o  (crc_busy),
    .fid_o   (fid)
  );

  flb_div #(.LANES(LANES)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc && !item_in.kind),
    .len_i     (item_in.pkt_length),
    .weight_i  (lane_weight),
    .n_i       (n_act),
    .busy_o    (div_busy),
    .nonzero_o (div_nonzero),
    .quot_o    (quot)
  );

  flb_table u_table (
    .clk_i     (clk_i),
    .req_i     (tbl_req),
    .rd_data_o (tbl_rd)
  );

  // Decisions on table data
  assign aged     = tbl_rd.valid && ((time_q - tbl_rd.last_time) > {32'd0, age_q});
  assign keep_d   = tbl_rd.valid && (time_q < (tbl_rd.last_time + {32'd0, hold_q}));
  assign port_sel = keep_q ? kept_port_q : 2'(best_idx_q);
  assign debit    = (3'(port_sel) < 3'(LANES));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      flb_pkg::ST_INIT:   if (&addr_q) state_d = flb_pkg::ST_IDLE;
      flb_pkg::ST_IDLE: begin
        if (in_acc) state_d = item_in.kind ? flb_pkg::ST_SWEEP : flb_pkg::ST_CALC;
      end
      flb_pkg::ST_CALC:   if (!div_busy && !crc_busy) state_d = flb_pkg::ST_CREDIT;
      flb_pkg::ST_CREDIT: state_d = flb_pkg::ST_LOOK;
      flb_pkg::ST_LOOK:   state_d = flb_pkg::ST_BEST;
      flb_pkg::ST_BEST:   if (best_i_q == LIDX'(LANES - 1)) state_d = flb_pkg::ST_WRITE;
      flb_pkg::ST_WRITE:  if (out_free) state_d = flb_pkg::ST_IDLE;
      flb_pkg::ST_SWEEP:  if (!rd_live_q && chk_valid_q) state_d = flb_pkg::ST_IDLE;
      default:            state_d = flb_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: table requests and input ready
  always_comb begin
    tbl_req         = '0;
    item_in.ready   = 1'b0;
    unique case (state_q)
      flb_pkg::ST_INIT: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = addr_q;
      end
      flb_pkg::ST_IDLE: item_in.ready = 1'b1;
      flb_pkg::ST_CREDIT: begin
        tbl_req.rd_en   = 1'b1;
        tbl_req.rd_addr = fid;
      end
      flb_pkg::ST_WRITE: begin
        tbl_req.wr_en             = out_free;
        tbl_req.wr_addr           = fid;
        tbl_req.wr_data.valid     = 1'b1;
        tbl_req.wr_data.last_time = time_q;
        tbl_req.wr_data.port      = port_sel;
      end
      flb_pkg::ST_SWEEP: begin
        tbl_req.rd_en             = rd_live_q;
        tbl_req.rd_addr           = addr_q;
        tbl_req.wr_en             = chk_valid_q && aged;
        tbl_req.wr_addr           = chk_addr_q;
        tbl_req.wr_data           = tbl_rd;
        tbl_req.wr_data.valid     = 1'b0;
      end
      default: ;
    endcase
  end

  // Sequencer and sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= flb_pkg::ST_INIT;
      addr_q      <= '0;
      rd_live_q   <= 1'b0;
      chk_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == flb_pkg::ST_INIT) begin
        addr_q <= addr_q + 1'b1;
      end else if (state_q == flb_pkg::ST_IDLE && in_acc && item_in.kind) begin
        addr_q      <= '0;
        rd_live_q   <= 1'b1;
        chk_valid_q <= 1'b0;
      end else if (state_q == flb_pkg::ST_SWEEP) begin
        chk_valid_q <= rd_live_q;
        if (rd_live_q) begin
          addr_q <= addr_q + 1'b1;
          if (&addr_q) rd_live_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers of one packet
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      time_q <= item_in.time_us;
      len_q  <= item_in.pkt_length;
    end
    if (state_q == flb_pkg::ST_SWEEP) chk_addr_q <= addr_q;
    if (state_q == flb_pkg::ST_CREDIT) begin
      best_idx_q <= '0;
      best_i_q   <= LIDX'(1);
    end
    if (state_q == flb_pkg::ST_LOOK) begin
      keep_q      <= keep_d;
      kept_port_q <= tbl_rd.port;
    end
    // Scan one candidate port per cycle
    if (state_q == flb_pkg::ST_BEST) begin
      if (3'(best_i_q) < n_act && flb_pkg::tok_less(tokens_q[best_idx_q], tokens_q[best_i_q])) begin
        best_idx_q <= best_i_q;
      end
      best_i_q <= best_i_q + 1'b1;
    end
  end

  // Token counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tokens_q <= '0;
    end else begin
      priority if (state_q == flb_pkg::ST_IDLE && in_acc && item_in.kind) begin
        for (int i = 0; i < LANES; i++) begin
          if (3'(i) < n_act) tokens_q[i] <= '0;
        end
      end else if (state_q == flb_pkg::ST_CREDIT && div_nonzero) begin
        for (int i = 0; i < LANES; i++) begin
          if (3'(i) < n_act) tokens_q[i] <= tokens_q[i] + 64'(quot[i]);
        end
      end else if (state_q == flb_pkg::ST_WRITE && out_free && debit) begin
        tokens_q[port_sel[LIDX-1:0]] <= tokens_q[port_sel[LIDX-1:0]] - 64'(len_q);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (state_q == flb_pkg::ST_WRITE && out_free) begin
      res_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == flb_pkg::ST_WRITE && out_free) begin
      res_fid_q  <= fid;
      res_port_q <= port_sel;
      res_new_q  <= !keep_q;
    end
  end

  assign res_out.valid      = res_valid_q;
  assign res_out.out_port   = res_port_q;
  assign res_out.flow_id    = res_fid_q;
  assign res_out.new_choice = res_new_q;

  // Configuration registers
  assign cfg_in.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_count_q <= flb_pkg::PORT_COUNT_RST;
      weight_q     <= {flb_pkg::MAX_LANES{flb_pkg::WEIGHT_RST}};
      hold_q       <= flb_pkg::HOLD_TIME_RST;
      age_q        <= flb_pkg::AGE_LIMIT_RST;
    end else if (cfg_in.valid) begin
      unique case (flb_pkg::cfg_reg_e'(cfg_in.index))
        flb_pkg::CFG_PORT_COUNT: port_count_q <= cfg_in.data[2:0];
        flb_pkg::CFG_WEIGHT_0:   weight_q[0]  <= cfg_in.data[15:0];
        flb_pkg::CFG_WEIGHT_1:   weight_q[1]  <= cfg_in.data[15:0];
        flb_pkg::CFG_WEIGHT_2:   weight_q[2]  <= cfg_in.data[15:0];
        flb_pkg::CFG_WEIGHT_3:   weight_q[3]  <= cfg_in.data[15:0];
        flb_pkg::CFG_HOLD_TIME:  hold_q       <= cfg_in.data;
        flb_pkg::CFG_AGE_LIMIT:  age_q        <= cfg_in.data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/flb_crc.sv]
// Byte-serial CRC-16 engine producing the flow id.
module flb_crc (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [flb_pkg::MSG_BITS-1:0] msg_i,
  output logic                         busy_o,
  output logic [15:0]                  fid_o
);

  logic [flb_pkg::MSG_BITS-1:0] msg_q;
  logic [15:0]                  crc_q;
  logic [3:0]                   cnt_q;

  // Count remaining bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 4'(flb_pkg::CRC_BYTES);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 4'd1;
    end
  end

  // Fold one byte per cycle, most significant byte of the message first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      msg_q <= msg_i;
      crc_q <= flb_pkg::CRC_INIT;
    end else if (cnt_q != '0) begin
      crc_q <= flb_pkg::crc_byte(crc_q, msg_q[flb_pkg::MSG_BITS-1 -: 8]);
      msg_q <= msg_q << 8;
    end
  end

  assign busy_o = (cnt_q != '0);
  // Invert and swap bytes
  assign fid_o  = {~crc_q[7:0], ~crc_q[15:8]};

endmodule

[hw/rtl/flb_div.sv]
// Per-port weighted share: multiply, then bit-serial restoring division.
module flb_div #(
  parameter int LANES = flb_pkg::MAX_LANES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [15:0]                    len_i,
  input  logic [LANES-1:0][15:0]         weight_i,
  input  logic [2:0]                     n_i,
  output logic                           busy_o,
  output logic                           nonzero_o,
  output logic [LANES-1:0][15:0]         quot_o
);

  logic [17:0]                    sum_d;
  logic [17:0]                    sum_q;
  logic [LANES-1:0][31:0]         prod;
  logic [LANES-1:0][17:0]         rem_q;
  logic [LANES-1:0][15:0]         low_q;
  logic [4:0]                     cnt_q;

  // Sum of active weights and the products
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < LANES; i++) begin
      prod[i] = 32'(len_i) * 32'(weight_i[i]);
      if (3'(i) < n_i) begin
        sum_d = sum_d + 18'(weight_i[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 5'(flb_pkg::QUOT_BITS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  // Upper product half is below the sum, so only sixteen quotient bits remain;
  // quotient bits shift into the low half as dividend bits leave it.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= sum_d;
      for (int i = 0; i < LANES; i++) begin
        rem_q[i] <= 18'(prod[i][31:16]);
        low_q[i] <= prod[i][15:0];
      end
    end else if (cnt_q != '0) begin
      for (int i = 0; i < LANES; i++) begin
        if ({rem_q[i], low_q[i][15]} >= {1'b0, sum_q}) begin
          rem_q[i] <= 18'({rem_q[i], low_q[i][15]} - {1'b0, sum_q});
          low_q[i] <= {low_q[i][14:0], 1'b1};
        end else begin
          rem_q[i] <= {rem_q[i][16:0], low_q[i][15]};
          low_q[i] <= {low_q[i][14:0], 1'b0};
        end
      end
    end
  end

  assign busy_o    = (cnt_q != '0);
  assign nonzero_o = (sum_q != '0);
  assign quot_o    = low_q;

endmodule

[hw/rtl/flb_table.sv]
// Flow table memory: one write port, one registered read port.
module flb_table (
  input  logic              clk_i,
  input  flb_pkg::tbl_req_t req_i,
  output flb_pkg::entry_t   rd_data_o
);

  flb_pkg::entry_t mem [flb_pkg::TABLE_DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem[req_i.rd_addr];
    end
  end

endmodule

[hw/rtl/flb_checker.sv]
// Port-level checks of the flowlet token load balancer, bound to the top level.
module flb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        item_valid,
  input logic        item_ready,
  input logic        item_kind,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_port,
  input logic [15:0] res_fid,
  input logic        res_new
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_port) && $stable(res_fid)
      && $stable(res_new))
    else $error("stalled result word changed");

  // One word at a time: accept drops ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && item_ready |=> !item_ready)
    else $error("input accepted while busy");

  // A new result only comes out of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> !$past(item_ready))
    else $error("result appeared without work");

  // A tick gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && item_ready && item_kind |=> !$rose(res_valid))
    else $error("tick produced a result");

endmodule

bind flowlet_token_load_balancer flb_checker u_flb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .item_valid (item_in.valid),
  .item_ready (item_in.ready),
  .item_kind  (item_in.kind),
  .res_valid  (res_out.valid),
  .res_ready  (res_out.ready),
  .res_port   (res_out.out_port),
  .res_fid    (res_out.flow_id),
  .res_new    (res_out.new_choice)
);
